### sv/intel_hex_record_writer_defines.svh
// Assertion macros for the Intel HEX record writer.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef INTEL_HEX_RECORD_WRITER_DEFINES_SVH
`define INTEL_HEX_RECORD_WRITER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define IHW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define IHW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ihw_pkg.sv
// Shared types, constants and the control store of the Intel HEX record writer.
// No dependencies.
package ihw_pkg;

    // Bytes per full data record (1..16)
    localparam int RECORD_BYTES = 16;
    localparam int BUF_DEPTH    = 16;
    localparam int BUF_AW       = 4;
    localparam int CNT_W        = 5;
    localparam int STEP_W       = 4;

    // Command codes
    localparam logic [1:0] CMD_APPEND   = 2'd0;
    localparam logic [1:0] CMD_SET_ADDR = 2'd1;
    localparam logic [1:0] CMD_CLOSE    = 2'd2;

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NL      = 8'h0A;

    // Fixed program addresses
    localparam logic [STEP_W-1:0] STEP_COLON   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DATA_HI = 4'd9;
    localparam logic [STEP_W-1:0] STEP_CSUM_HI = 4'd11;

    typedef enum logic [1:0] {
        CH_COLON,
        CH_HI,
        CH_LO,
        CH_NEWLINE
    } char_sel_t;

    typedef enum logic [2:0] {
        BS_COUNT,
        BS_ADDR_HI,
        BS_ADDR_LO,
        BS_TYPE,
        BS_DATA,
        BS_CSUM
    } byte_sel_t;

    typedef enum logic [1:0] {
        CD_NONE,       // fall through
        CD_DATA_DONE,  // jump when all data bytes sent
        CD_DATA_MORE,  // jump while data bytes remain
        CD_REC_END     // end of record: chain end record or stop
    } cond_t;

    typedef struct packed {
        char_sel_t         char_sel;
        byte_sel_t         byte_sel;
        logic              sum_add;
        logic              idx_inc;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    // Buffer write port bundle
    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } buf_wr_t;

    // Upper-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        case (nib)
            4'h0: ch = 8'h30;
            4'h1: ch = 8'h31;
            4'h2: ch = 8'h32;
            4'h3: ch = 8'h33;
            4'h4: ch = 8'h34;
            4'h5: ch = 8'h35;
            4'h6: ch = 8'h36;
            4'h7: ch = 8'h37;
            4'h8: ch = 8'h38;
            4'h9: ch = 8'h39;
            4'hA: ch = 8'h41;
            4'hB: ch = 8'h42;
            4'hC: ch = 8'h43;
            4'hD: ch = 8'h44;
            4'hE: ch = 8'h45;
            default: ch = 8'h46;
        endcase
        return ch;
    endfunction

    // Record program: one character per step
    function automatic ctrl_word_t ctrl_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = '{CH_NEWLINE, BS_COUNT, 1'b0, 1'b0, CD_REC_END, STEP_COLON};
        unique case (step)
            4'd0:  w = '{CH_COLON,   BS_COUNT,   1'b0, 1'b0, CD_NONE,      STEP_COLON};
            4'd1:  w = '{CH_HI,      BS_COUNT,   1'b0, 1'b0, CD_NONE,      STEP_COLON};
            4'd2:  w = '{CH_LO,      BS_COUNT,   1'b1, 1'b0, CD_NONE,      STEP_COLON};
            4'd3:  w = '{CH_HI,      BS_ADDR_HI, 1'b0, 1'b0, CD_NONE,      STEP_COLON};
            4'd4:  w = '{CH_LO,      BS_ADDR_HI, 1'b1, 1'b0, CD_NONE,      STEP_COLON};
            4'd5:  w = '{CH_HI,      BS_ADDR_LO, 1'b0, 1'b0, CD_NONE,      STEP_COLON};
            4'd6:  w = '{CH_LO,      BS_ADDR_LO, 1'b1, 1'b0, CD_NONE,      STEP_COLON};
            4'd7:  w = '{CH_HI,      BS_TYPE,    1'b0, 1'b0, CD_NONE,      STEP_COLON};
            4'd8:  w = '{CH_LO,      BS_TYPE,    1'b1, 1'b0, CD_DATA_DONE, STEP_CSUM_HI};
            4'd9:  w = '{CH_HI,      BS_DATA,    1'b0, 1'b0, CD_NONE,      STEP_COLON};
            4'd10: w = '{CH_LO,      BS_DATA,    1'b1, 1'b1, CD_DATA_MORE, STEP_DATA_HI};
            4'd11: w = '{CH_HI,      BS_CSUM,    1'b0, 1'b0, CD_NONE,      STEP_COLON};
            4'd12: w = '{CH_LO,      BS_CSUM,    1'b0, 1'b0, CD_NONE,      STEP_COLON};
            4'd13: w = '{CH_NEWLINE, BS_COUNT,   1'b0, 1'b0, CD_REC_END,   STEP_COLON};
            default: w = '{CH_NEWLINE, BS_COUNT, 1'b0, 1'b0, CD_REC_END,   STEP_COLON};
        endcase
        return w;
    endfunction

endpackage

### sv/ihw_in_if.sv
// Command channel of the Intel HEX record writer.
// Depends on nothing.
interface ihw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic [15:0] load_address;
    logic        emit_enable;

    modport source (output valid, command, data_byte, load_address, emit_enable,
                    input ready);
    modport sink   (input valid, command, data_byte, load_address, emit_enable,
                    output ready);
endinterface

### sv/ihw_out_if.sv
// Character channel of the Intel HEX record writer.
// Depends on nothing.
interface ihw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, out_char, last, input ready);
    modport sink   (input valid, out_char, last, output ready);
endinterface

### sv/ihw_byte_buf.sv
// Pending data byte store: one write port, one registered read port.
// Depends on ihw_pkg.
module ihw_byte_buf (
    input  logic                       clk,
    input  ihw_pkg::buf_wr_t           wr,
    input  logic [ihw_pkg::BUF_AW-1:0] rd_addr,
    output logic [7:0]                 rd_data
);
    import ihw_pkg::*;

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

### sv/intel_hex_record_writer.sv
// Intel HEX record writer. Commands arrive one at a time; a command that
// produces no text (append below a full record, address set with nothing
// pending, unknown code) is taken without holding the channel. A command
// that emits a record holds the command channel while a microcoded
// sequencer sends the text at one character per cycle: a record of n data
// bytes is a colon, four header bytes, the data, the checksum and a newline;
// a close with bytes pending sends two records back to back. The character
// output register sets the pace; downstream stalls stretch it.
// Depends on ihw_pkg, ihw_in_if, ihw_out_if, ihw_byte_buf and the defines header.
`include "intel_hex_record_writer_defines.svh"

module intel_hex_record_writer (
    input  logic      clk,
    input  logic      rst_n,
    ihw_in_if.sink    cmd,
    ihw_out_if.source text
);
    import ihw_pkg::*;

    // Sequencer and record state
    logic                busy_reg,     busy_next;
    logic [STEP_W-1:0]   step_reg,     step_next;
    logic [CNT_W-1:0]    idx_reg,      idx_next;
    logic [CNT_W-1:0]    cnt_reg,      cnt_next;
    logic [CNT_W-1:0]    count_reg,    count_next;
    logic [15:0]         addr_reg,     addr_next;
    logic [15:0]         pend_addr_reg, pend_addr_next;
    logic                addr_pend_reg, addr_pend_next;
    logic                end_pend_reg, end_pend_next;
    logic                type_reg,     type_next;
    logic [7:0]          sum_reg,      sum_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;

    ctrl_word_t          ctrl;
    buf_wr_t             buf_wr;
    logic [7:0]          rd_data;
    logic                accept;
    logic                advance;
    logic [7:0]          sel_byte;
    logic [7:0]          sel_char;
    logic [CNT_W-1:0]    count_inc;

    assign cmd.ready  = !busy_reg;
    assign accept     = cmd.valid && !busy_reg;
    assign advance    = busy_reg && (!out_valid_reg || text.ready);
    assign ctrl       = ctrl_rom(step_reg);
    assign count_inc  = count_reg + CNT_W'(1);

    assign text.valid    = out_valid_reg;
    assign text.out_char = out_char_reg;
    assign text.last     = out_last_reg;

    // Read ahead at the next index so rd_data always holds the current byte
    ihw_byte_buf u_buf (
        .clk     (clk),
        .wr      (buf_wr),
        .rd_addr (idx_next[BUF_AW-1:0]),
        .rd_data (rd_data)
    );

    // Buffer write on an enabled append
    always_comb
    begin
        buf_wr.en   = accept && (cmd.command == CMD_APPEND) && cmd.emit_enable;
        buf_wr.addr = count_reg[BUF_AW-1:0];
        buf_wr.data = cmd.data_byte;
    end

    // Datapath: byte and character select
    always_comb
    begin
        case (ctrl.byte_sel)
            BS_COUNT:   sel_byte = {{(8-CNT_W){1'b0}}, cnt_reg};
            BS_ADDR_HI: sel_byte = addr_reg[15:8];
            BS_ADDR_LO: sel_byte = addr_reg[7:0];
            BS_TYPE:    sel_byte = {7'd0, type_reg};
            BS_DATA:    sel_byte = rd_data;
            default:    sel_byte = 8'd0 - sum_reg;
        endcase
        case (ctrl.char_sel)
            CH_COLON: sel_char = CHAR_COLON;
            CH_HI:    sel_char = hex_char(sel_byte[7:4]);
            CH_LO:    sel_char = hex_char(sel_byte[3:0]);
            default:  sel_char = CHAR_NL;
        endcase
    end

    // Command decode and sequencer next state
    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        pend_addr_next = pend_addr_reg;
        addr_pend_next = addr_pend_reg;
        end_pend_next  = end_pend_reg;
        type_next      = type_reg;
        sum_next       = sum_reg;

        if (accept)
        begin
            case (cmd.command)
                CMD_APPEND:
                begin
                    if (cmd.emit_enable)
                    begin
                        count_next = count_inc;
                        if (count_inc == CNT_W'(RECORD_BYTES))
                        begin
                            busy_next = 1'b1;
                            step_next = STEP_COLON;
                            idx_next  = '0;
                            cnt_next  = count_inc;
                            type_next = 1'b0;
                        end
                    end
                end
                CMD_SET_ADDR:
                begin
                    if (cmd.emit_enable)
                    begin
                        if (count_reg != '0)
                        begin
                            busy_next      = 1'b1;
                            step_next      = STEP_COLON;
                            idx_next       = '0;
                            cnt_next       = count_reg;
                            type_next      = 1'b0;
                            pend_addr_next = cmd.load_address;
                            addr_pend_next = 1'b1;
                        end
                        else
                        begin
                            addr_next = cmd.load_address;
                        end
                    end
                end
                CMD_CLOSE:
                begin
                    busy_next = 1'b1;
                    step_next = STEP_COLON;
                    idx_next  = '0;
                    cnt_next  = count_reg;
                    // Flush first if bytes are pending, then the end record
                    if (count_reg != '0)
                    begin
                        type_next     = 1'b0;
                        end_pend_next = 1'b1;
                    end
                    else
                    begin
                        type_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (advance)
        begin
            if (ctrl.char_sel == CH_COLON)
            begin
                sum_next = 8'd0;
            end
            else if (ctrl.sum_add)
            begin
                sum_next = sum_reg + sel_byte;
            end
            if (ctrl.idx_inc)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end

            step_next = step_reg + STEP_W'(1);
            case (ctrl.cond)
                CD_DATA_DONE:
                begin
                    if (idx_reg == cnt_reg)
                    begin
                        step_next = ctrl.target;
                    end
                end
                CD_DATA_MORE:
                begin
                    // Index moves on with this step; loop if more remain
                    if ((idx_reg + CNT_W'(1)) != cnt_reg)
                    begin
                        step_next = ctrl.target;
                    end
                end
                CD_REC_END:
                begin
                    // Record done: advance the load address (or take the pending one), drop the buffer
                    count_next     = '0;
                    addr_pend_next = 1'b0;
                    addr_next      = addr_pend_reg ? pend_addr_reg
                                                   : addr_reg + {{(16-CNT_W){1'b0}}, cnt_reg};
                    step_next      = ctrl.target;
                    idx_next       = '0;
                    if (end_pend_reg)
                    begin
                        end_pend_next = 1'b0;
                        type_next     = 1'b1;
                        cnt_next      = '0;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_char_next  = sel_char;
            out_last_next  = (ctrl.cond == CD_REC_END) && !end_pend_reg;
        end
        else if (text.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_COLON;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            count_reg     <= '0;
            addr_reg      <= '0;
            addr_pend_reg <= 1'b0;
            end_pend_reg  <= 1'b0;
            type_reg      <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            addr_pend_reg <= addr_pend_next;
            end_pend_reg  <= end_pend_next;
            type_reg      <= type_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

    // Checks
    `IHW_ASSERT_NOW(a_idle_at_start, !busy_reg, step_reg == STEP_COLON, "idle sequencer off step 0")
    `IHW_ASSERT_NOW(a_idx_bound, busy_reg, idx_reg <= cnt_reg, "data index past record count")
    `IHW_ASSERT_NOW(a_last_is_nl, text.valid && text.last, text.out_char == CHAR_NL, "last char not newline")
    `IHW_ASSERT_NEXT(a_close_busy, accept && (cmd.command == CMD_CLOSE), busy_reg, "close did not start a record")

endmodule
